/* design/rvalu_pkg.sv */
// ----------------------------------------------------------------------------
// rvalu_pkg
// Shared operation codes, pipeline word type and helpers for the RV32IM ALU.
// ----------------------------------------------------------------------------
package rvalu_pkg;

  localparam int unsigned XLEN   = 32;
  localparam int unsigned FUNC_W = 11;
  localparam int unsigned NCELLS = 32;

  localparam logic [FUNC_W-1:0] OP_ADD    = 11'h000;
  localparam logic [FUNC_W-1:0] OP_SUB    = 11'h200;
  localparam logic [FUNC_W-1:0] OP_XOR    = 11'h004;
  localparam logic [FUNC_W-1:0] OP_OR     = 11'h006;
  localparam logic [FUNC_W-1:0] OP_AND    = 11'h007;
  localparam logic [FUNC_W-1:0] OP_SLL    = 11'h001;
  localparam logic [FUNC_W-1:0] OP_SRL    = 11'h005;
  localparam logic [FUNC_W-1:0] OP_SRA    = 11'h205;
  localparam logic [FUNC_W-1:0] OP_SLT    = 11'h002;
  localparam logic [FUNC_W-1:0] OP_SLTU   = 11'h003;
  localparam logic [FUNC_W-1:0] OP_MUL    = 11'h010;
  localparam logic [FUNC_W-1:0] OP_MULH   = 11'h011;
  localparam logic [FUNC_W-1:0] OP_MULHSU = 11'h012;
  localparam logic [FUNC_W-1:0] OP_MULHU  = 11'h013;
  localparam logic [FUNC_W-1:0] OP_DIV    = 11'h014;
  localparam logic [FUNC_W-1:0] OP_DIVU   = 11'h015;
  localparam logic [FUNC_W-1:0] OP_REM    = 11'h016;
  localparam logic [FUNC_W-1:0] OP_REMU   = 11'h017;

  localparam logic [XLEN-1:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    K_DONE,
    K_MUL,
    K_DIV
  } kind_t;

  // One word travelling down the cell row.
  typedef struct packed {
    logic            vld;
    kind_t           kind;
    logic            hi;     // multiply: take upper half
    logic            rem;    // divide: take remainder
    logic            neg;    // negate final value
    logic            bypass; // divide: result already known
    logic [XLEN-1:0] rmd;    // partial remainder / product high
    logic [XLEN-1:0] quo;    // dividend bits / multiplier bits
    logic [XLEN-1:0] dvs;    // divisor / multiplicand
    logic [XLEN-1:0] res;    // finished value
    logic            ill;
  } word_t;

  function automatic logic [XLEN-1:0] mag(input logic [XLEN-1:0] v, input logic s);
    mag = (s && v[XLEN-1]) ? (~v + 1'b1) : v;
  endfunction

endpackage

/* design/rv32im_register_alu_core.sv */
// ----------------------------------------------------------------------------
// rv32im_register_alu_core
// RV32IM register-register ALU built as a row of identical bit cells.
// ----------------------------------------------------------------------------
// Every operation passes the 32 cell registers and then one output register;
// done for it is seen from the output register once start has been taken.
// Throughput: one word per cycle; busy is never raised, the row is pipelined.
// The 32 bit cells each retire one multiplier or quotient bit per cycle.
// Reset clears the valid bits of the row; done is low after reset.
// The receiver cannot stall: done is shown for one cycle only.
// ----------------------------------------------------------------------------
module rv32im_register_alu_core import rvalu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] func,
  input  logic [XLEN-1:0]   rs1_value,
  input  logic [XLEN-1:0]   rs2_value,
  output logic              done,
  output logic [XLEN-1:0]   result,
  output logic              illegal
);

  // The row never blocks, so new words are always welcome.
  assign busy = 1'b0;

  // Decoded word entering the row, then the word between each pair of cells.
  word_t row [NCELLS+1];

  rvalu_decode u_dec (
    .start     (start),
    .func      (func),
    .rs1_value (rs1_value),
    .rs2_value (rs2_value),
    .w         (row[0])
  );

  // Each cell performs one shift-add or one trial subtraction and registers
  // the word, so all operations share the same fixed latency and order.
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    rvalu_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (row[i]),
      .dout (row[i+1])
    );
  end

  rvalu_finish u_fin (
    .clk     (clk),
    .rst     (rst),
    .w       (row[NCELLS]),
    .done    (done),
    .result  (result),
    .illegal (illegal)
  );

endmodule

/* design/rvalu_cell.sv */
// ----------------------------------------------------------------------------
// rvalu_cell
// One step of the cell row: one shift-add multiply bit or one restoring
// division bit (finished words pass unchanged), registered for the next cell.
// ----------------------------------------------------------------------------
module rvalu_cell import rvalu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  word_t din,
  output word_t dout
);

  word_t             w_next;
  logic [XLEN:0]     sum;
  logic [XLEN:0]     trial;

  always_comb begin
    w_next = din;
    sum    = '0;
    trial  = '0;
    unique case (din.kind)
      K_MUL: begin
        // Unsigned shift-add: {rmd,quo} holds product high and multiplier.
        sum = {1'b0, din.rmd} + (din.quo[0] ? {1'b0, din.dvs} : '0);
        w_next.rmd = sum[XLEN:1];
        w_next.quo = {sum[0], din.quo[XLEN-1:1]};
      end
      K_DIV: begin
        trial = {din.rmd, din.quo[XLEN-1]} - {1'b0, din.dvs};
        if (!trial[XLEN]) begin
          w_next.rmd = trial[XLEN-1:0];
          w_next.quo = {din.quo[XLEN-2:0], 1'b1};
        end else begin
          w_next.rmd = {din.rmd[XLEN-2:0], din.quo[XLEN-1]};
          w_next.quo = {din.quo[XLEN-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.kind   <= w_next.kind;
    dout.hi     <= w_next.hi;
    dout.rem    <= w_next.rem;
    dout.neg    <= w_next.neg;
    dout.bypass <= w_next.bypass;
    dout.rmd    <= w_next.rmd;
    dout.quo    <= w_next.quo;
    dout.dvs    <= w_next.dvs;
    dout.res    <= w_next.res;
    dout.ill    <= w_next.ill;
  end

endmodule

/* design/rvalu_decode.sv */
// ----------------------------------------------------------------------------
// rvalu_decode
// Decodes the function code, finishes base operations at once and prepares
// operand magnitudes and sign corrections for the multiply/divide row.
// ----------------------------------------------------------------------------
module rvalu_decode import rvalu_pkg::*; (
  input  logic              start,
  input  logic [FUNC_W-1:0] func,
  input  logic [XLEN-1:0]   rs1_value,
  input  logic [XLEN-1:0]   rs2_value,
  output word_t             w
);

  logic [4:0]      sh;
  logic            sa;
  logic            sb;
  logic [XLEN-1:0] ma;
  logic [XLEN-1:0] mb;

  assign sh = rs2_value[4:0];

  always_comb begin
    w     = '0;
    w.vld = start;
    w.kind = K_DONE;
    sa = 1'b0;
    sb = 1'b0;
    unique case (func)
      OP_MUL:    begin sa = 1'b1; sb = 1'b1; end
      OP_MULH:   begin sa = 1'b1; sb = 1'b1; w.hi = 1'b1; end
      OP_MULHSU: begin sa = 1'b1; w.hi = 1'b1; end
      OP_MULHU:  w.hi = 1'b1;
      OP_DIV:    begin sa = 1'b1; sb = 1'b1; end
      OP_REM:    begin sa = 1'b1; sb = 1'b1; w.rem = 1'b1; end
      OP_REMU:   w.rem = 1'b1;
      default: ;
    endcase
    ma = mag(rs1_value, sa);
    mb = mag(rs2_value, sb);
    unique case (func)
      OP_ADD:  w.res = rs1_value + rs2_value;
      OP_SUB:  w.res = rs1_value - rs2_value;
      OP_XOR:  w.res = rs1_value ^ rs2_value;
      OP_OR:   w.res = rs1_value | rs2_value;
      OP_AND:  w.res = rs1_value & rs2_value;
      OP_SLL:  w.res = rs1_value << sh;
      OP_SRL:  w.res = rs1_value >> sh;
      OP_SRA:  w.res = XLEN'($signed(rs1_value) >>> sh);
      OP_SLT:  w.res = {{(XLEN-1){1'b0}}, $signed(rs1_value) < $signed(rs2_value)};
      OP_SLTU: w.res = {{(XLEN-1){1'b0}}, rs1_value < rs2_value};
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU: begin
        w.kind = K_MUL;
        w.quo  = ma;
        w.dvs  = mb;
        w.neg  = (sa && rs1_value[XLEN-1]) ^ (sb && rs2_value[XLEN-1]);
      end
      OP_DIV, OP_DIVU, OP_REM, OP_REMU: begin
        w.kind = K_DIV;
        w.quo  = ma;
        w.dvs  = mb;
        if (rs2_value == '0) begin
          // Divide by zero: all ones, or the dividend for a remainder.
          w.bypass = 1'b1;
          w.res    = w.rem ? rs1_value : ALL_ONES;
        end else if (w.rem) begin
          w.neg = sa && rs1_value[XLEN-1];
        end else begin
          w.neg = sa && (rs1_value[XLEN-1] ^ rs2_value[XLEN-1]);
        end
      end
      default: w.ill = 1'b1;
    endcase
  end

endmodule

/* design/rvalu_finish.sv */
// ----------------------------------------------------------------------------
// rvalu_finish
// Selects the half or quotient/remainder at the end of the row, applies the
// sign correction and registers the result word.
// ----------------------------------------------------------------------------
module rvalu_finish import rvalu_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  word_t           w,
  output logic            done,
  output logic [XLEN-1:0] result,
  output logic            illegal
);

  logic [2*XLEN-1:0] prod;
  logic [2*XLEN-1:0] sprod;
  logic [XLEN-1:0]   v;
  logic [XLEN-1:0]   val;

  assign prod  = {w.rmd, w.quo};
  assign sprod = w.neg ? (~prod + 1'b1) : prod;

  always_comb begin
    v = w.rem ? w.rmd : w.quo;
    unique case (w.kind)
      K_MUL:   val = w.hi ? sprod[2*XLEN-1:XLEN] : sprod[XLEN-1:0];
      K_DIV:   val = w.bypass ? w.res : (w.neg ? (~v + 1'b1) : v);
      default: val = w.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= w.vld;
    end
    result  <= val;
    illegal <= w.ill;
  end

endmodule

/* design/rvalu_checker.sv */
// ----------------------------------------------------------------------------
// rvalu_checker
// Port-level checks on the ALU's result strobe and flags.
// ----------------------------------------------------------------------------
module rvalu_checker import rvalu_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [XLEN-1:0]   result,
  input logic              illegal
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##33 done)
    else $error("result word missing after 33 cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 33))
    else $error("result word without a start");

  a_illegal_zero: assert property (@(posedge clk) disable iff (rst)
    (done && illegal) |-> (result == '0))
    else $error("illegal word carries a non-zero result");

endmodule

bind rv32im_register_alu_core rvalu_checker u_chk (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result),
  .illegal (illegal)
);
